[hw/rtl/gim_pkg.sv]
// ----------------------------------------------------------------------------
// gim_pkg
// shared types and constants of the greedy iou interval matcher
// ----------------------------------------------------------------------------
package gim_pkg;
  localparam int MAX_TRUTH_DEF = 16;
  localparam int MAX_PRED_DEF  = 16;
  localparam int TIME_BITS_DEF = 32;
  localparam int IOU_W  = 17;
  localparam int OV_W   = 32;
  localparam int ERR_W  = 33;
  localparam int ID_W   = 8;
  localparam int IDX_W  = 4;
  localparam logic [IOU_W-1:0] MIN_IOU_RST = 17'd6554;

  typedef enum logic [1:0] {
    OP_LOAD_TRUTH = 2'd0,
    OP_LOAD_PRED  = 2'd1,
    OP_RUN        = 2'd2,
    OP_NONE       = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_MATCH  = 2'd0,
    KIND_UPRED  = 2'd1,
    KIND_UTRUTH = 2'd2,
    KIND_EMPTY  = 2'd3
  } kind_t;

  typedef enum logic [0:0] {
    CFG_MIN_IOU = 1'd0,
    CFG_SAME_LABEL = 1'd1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCAN, ST_DIV, ST_CMP1, ST_CMP2, ST_TAKE, ST_EMIT_UP, ST_EMIT_UT,
    ST_EMPTY, ST_WAIT
  } state_t;
endpackage

[hw/rtl/gim_if.sv]
// ----------------------------------------------------------------------------
// gim_if
// request, result and config channels of the matcher
// ----------------------------------------------------------------------------
interface gim_in_if;
  logic valid;
  logic ready;
  logic [1:0] op;
  logic [31:0] start_time;
  logic [31:0] end_time;
  logic [7:0] channel_id;
  logic [7:0] label_id;
  modport source(output valid, op, start_time, end_time, channel_id, label_id,
                 input ready);
  modport sink(input valid, op, start_time, end_time, channel_id, label_id,
               output ready);
endinterface

interface gim_out_if;
  logic valid;
  logic ready;
  logic [1:0] kind;
  logic [3:0] truth_idx;
  logic [3:0] pred_idx;
  logic [16:0] iou_q16;
  logic [31:0] overlap_ticks;
  logic [32:0] boundary_error;
  logic last;
  modport source(output valid, kind, truth_idx, pred_idx, iou_q16,
                 overlap_ticks, boundary_error, last, input ready);
  modport sink(input valid, kind, truth_idx, pred_idx, iou_q16,
               overlap_ticks, boundary_error, last, output ready);
endinterface

interface gim_cfg_if;
  logic valid;
  logic ready;
  logic [0:0] index;
  logic [31:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

[hw/rtl/greedy_iou_interval_matcher_top.sv]
// ----------------------------------------------------------------------------
// greedy_iou_interval_matcher_top
// greedy one-to-one iou matching of reference and predicted intervals
// ----------------------------------------------------------------------------
// requests on in: op 0 loads a reference interval, op 1 a prediction, op 2
// runs the matching, op 3 is dropped. loads past capacity are dropped. in is
// ready only while no run is in progress.
// a run scans every free pair once per selection round. each pair is read from
// memory and checked for channel, label and overlap; one that passes goes
// through a one-bit-per-cycle divider for the q16 iou, then a compare on
// TIME_BITS x (TIME_BITS+1) bit cross products. each round ends by taking
// the best pair, and the run ends by listing the unmatched ones. a full
// 16 by 16 run stays under about 1500 pair evaluations.
// results leave on out through a single output register: matches in order
// taken, then unmatched predictions, then unmatched references, last on the
// final one. a run with nothing loaded gives one result of kind 3.
// a stalled receiver holds the output register; while it is full, the run
// holds at each take, each unmatched-list step and at its end.
// reset clears counts and taken flags, resets config, not interval memories.
// config writes are accepted any time and must be made while idle.
// ----------------------------------------------------------------------------
module greedy_iou_interval_matcher_top import gim_pkg::*; #(
  parameter int MAX_TRUTH = MAX_TRUTH_DEF,
  parameter int MAX_PRED  = MAX_PRED_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input logic clk,
  input logic rst,
  gim_in_if.sink  in,
  gim_out_if.source out,
  gim_cfg_if.sink cfg
);
  localparam int TB = TIME_BITS;
  localparam int W  = 2 * TB + 16;
  localparam int TCW = $clog2(MAX_TRUTH + 1);
  localparam int PCW = $clog2(MAX_PRED + 1);
  localparam int TAW = (MAX_TRUTH > 1) ? $clog2(MAX_TRUTH) : 1;
  localparam int PAW = (MAX_PRED > 1) ? $clog2(MAX_PRED) : 1;
  localparam int PW = 2 * TB + 2;
  localparam int EW = TB + 1;

  state_t state, state_next;
  logic [IOU_W-1:0] min_iou;
  logic same_label;
  logic [TCW-1:0] tcnt, ti;
  logic [PCW-1:0] pcnt, pj;
  logic [MAX_TRUTH-1:0] ttaken;
  logic [MAX_PRED-1:0] ptaken;
  logic [W-1:0] trd, prd;
  logic [W-1:0] wdata;
  logic rd_ok, rd_ok_next;
  logic found;
  logic [TCW-1:0] bt;
  logic [PCW-1:0] bp;
  logic [TB-1:0] bov, cov;
  logic [TB:0] bun, cun;
  logic [IOU_W-1:0] bq;
  logic [EW-1:0] berr, cerr;
  logic [PW-1:0] pa, pb;
  logic div_go, div_busy;
  logic [IOU_W-1:0] div_q;
  logic ovalid;
  logic [1:0] okind;
  logic [3:0] oti, opi;
  logic [IOU_W-1:0] oq;
  logic [OV_W-1:0] oov;
  logic [ERR_W-1:0] oerr;
  logic olast;
  logic emit;
  logic [1:0] emit_kind;
  logic [3:0] emit_ti, emit_pi;
  logic emit_last;

  assign wdata = {TB'(in.start_time), TB'(in.end_time), in.channel_id,
                  in.label_id};
  assign in.ready = (state == ST_IDLE);
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_iou <= MIN_IOU_RST;
      same_label <= 1'b1;
    end else if (cfg.valid) begin
      unique case (cfg_idx_t'(cfg.index))
        CFG_MIN_IOU: min_iou <= cfg.data[IOU_W-1:0];
        CFG_SAME_LABEL: same_label <= cfg.data[0];
        default: ;
      endcase
    end
  end

  logic twe, pwe;
  assign twe = in.valid && in.ready && op_t'(in.op) == OP_LOAD_TRUTH &&
               tcnt < TCW'(MAX_TRUTH);
  assign pwe = in.valid && in.ready && op_t'(in.op) == OP_LOAD_PRED &&
               pcnt < PCW'(MAX_PRED);

  gim_store #(.DEPTH(MAX_TRUTH), .W(W)) u_tstore (
    .clk, .we(twe), .waddr(tcnt), .wdata, .raddr(ti), .rdata(trd));
  gim_store #(.DEPTH(MAX_PRED), .W(W)) u_pstore (
    .clk, .we(pwe), .waddr(pcnt), .wdata, .raddr(pj), .rdata(prd));

  // pair evaluation on registered memory data
  logic [TB-1:0] ts, te, ps, pe, lo, hi;
  logic [TB-1:0] ov_c;
  logic [TB:0] un_c;
  logic [EW-1:0] err_c;
  logic elig_pre;
  assign ts = trd[W-1 -: TB];
  assign te = trd[W-1-TB -: TB];
  assign ps = prd[W-1 -: TB];
  assign pe = prd[W-1-TB -: TB];
  assign lo = (ts > ps) ? ts : ps;
  assign hi = (te < pe) ? te : pe;
  assign elig_pre = (trd[15:8] == prd[15:8]) &&
                    (!same_label || trd[7:0] == prd[7:0]) && (hi > lo);
  assign ov_c = hi - lo;
  assign un_c = ({1'b0, te - ts} + {1'b0, pe - ps}) - {1'b0, ov_c};
  assign err_c = EW'((ps > ts) ? ps - ts : ts - ps) +
                 EW'((pe > te) ? pe - te : te - pe);

  gim_div #(.TB(TB)) u_div (
    .clk, .rst, .go(div_go), .ov(ov_c), .un(un_c), .busy(div_busy), .q(div_q));

  logic tfree, pfree, scan_end;
  assign tfree = (ti < tcnt) && !ttaken[ti[TAW-1:0]];
  assign pfree = (pj < pcnt) && !ptaken[pj[PAW-1:0]];
  assign scan_end = (ti == tcnt);

  // last detection: no later free entries and (for preds) no free truth
  logic lastp, lastt, take_last;
  logic [MAX_PRED-1:0] pmask_after;
  logic [MAX_TRUTH-1:0] tmask_after, tvalid;
  logic [MAX_PRED-1:0] pvalid;
  always_comb begin
    for (int k = 0; k < MAX_PRED; k++) begin
      pvalid[k] = PCW'(k) < pcnt;
      pmask_after[k] = pvalid[k] && !ptaken[k] && PCW'(k) > pj;
    end
    for (int k = 0; k < MAX_TRUTH; k++) begin
      tvalid[k] = TCW'(k) < tcnt;
      tmask_after[k] = tvalid[k] && !ttaken[k] && TCW'(k) > ti;
    end
  end
  assign lastp = (pmask_after == '0) && ((tvalid & ~ttaken) == '0);
  assign lastt = (tmask_after == '0);
  // a match is final when it leaves no free entry on either side
  assign take_last = ((tvalid & ~ttaken & ~(MAX_TRUTH'(1) << bt)) == '0) &&
                     ((pvalid & ~ptaken & ~(MAX_PRED'(1) << bp)) == '0);

  always_comb begin
    state_next = state;
    div_go = 1'b0;
    rd_ok_next = 1'b0;
    unique case (state)
      ST_IDLE:
        if (in.valid && op_t'(in.op) == OP_RUN)
          state_next = (tcnt == '0 && pcnt == '0) ? ST_EMPTY : ST_SCAN;
      ST_SCAN:
        if (scan_end) state_next = found ? ST_TAKE : ST_EMIT_UP;
        else if (!rd_ok) rd_ok_next = 1'b1;
        else if (tfree && pfree && elig_pre) begin
          state_next = ST_DIV;
          div_go = 1'b1;
          rd_ok_next = 1'b1;
        end
      ST_DIV: begin
        rd_ok_next = 1'b1;
        if (!div_busy && !rd_ok) state_next = ST_DIV;
        else if (!div_busy) state_next = ST_CMP1;
      end
      ST_CMP1: state_next = ST_CMP2;
      ST_CMP2: state_next = ST_SCAN;
      ST_TAKE: if (!ovalid || out.ready) state_next = ST_SCAN;
      ST_EMIT_UP: if ((!ovalid || out.ready) && pj == pcnt) state_next = ST_EMIT_UT;
      ST_EMIT_UT: if ((!ovalid || out.ready) && ti == tcnt) state_next = ST_WAIT;
      ST_EMPTY: if (!ovalid || out.ready) state_next = ST_WAIT;
      ST_WAIT: if (!ovalid) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // output request selection
  always_comb begin
    emit = 1'b0;
    emit_kind = KIND_MATCH;
    emit_ti = '0;
    emit_pi = '0;
    emit_last = 1'b0;
    unique case (state)
      ST_TAKE: begin
        emit = !ovalid || out.ready;
        emit_ti = 4'(bt);
        emit_pi = 4'(bp);
        emit_last = take_last;
      end
      ST_EMIT_UP: begin
        emit = (!ovalid || out.ready) && pj != pcnt && pfree;
        emit_kind = KIND_UPRED;
        emit_pi = 4'(pj);
        emit_last = lastp;
      end
      ST_EMIT_UT: begin
        emit = (!ovalid || out.ready) && ti != tcnt && tfree;
        emit_kind = KIND_UTRUTH;
        emit_ti = 4'(ti);
        emit_last = lastt;
      end
      ST_EMPTY: begin
        emit = !ovalid || out.ready;
        emit_kind = KIND_EMPTY;
        emit_last = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      tcnt <= '0;
      pcnt <= '0;
      ttaken <= '0;
      ptaken <= '0;
      ti <= '0;
      pj <= '0;
      rd_ok <= 1'b0;
      found <= 1'b0;
      ovalid <= 1'b0;
    end else begin
      state <= state_next;
      rd_ok <= rd_ok_next;
      if (twe) tcnt <= tcnt + 1'b1;
      if (pwe) pcnt <= pcnt + 1'b1;
      ovalid <= emit ? 1'b1 : ((out.valid && out.ready) ? 1'b0 : ovalid);
      if (emit) begin
        okind <= emit_kind;
        oti <= emit_ti;
        opi <= emit_pi;
        olast <= emit_last;
        oq <= (state == ST_TAKE) ? bq : '0;
        oov <= (state == ST_TAKE) ? OV_W'(bov) : '0;
        oerr <= (state == ST_TAKE) ? ERR_W'(berr) : '0;
      end
      unique case (state)
        ST_IDLE: begin
          ti <= '0;
          pj <= '0;
          found <= 1'b0;
        end
        ST_SCAN: begin
          if (scan_end) begin
            ti <= '0;
            pj <= '0;
          end else if (rd_ok) begin
            if (tfree && pfree && elig_pre) begin
              cov <= ov_c;
              cun <= un_c;
              cerr <= err_c;
            end else begin
              if (pj + 1'b1 >= pcnt) begin
                pj <= '0;
                ti <= ti + 1'b1;
              end else pj <= pj + 1'b1;
            end
          end
        end
        ST_CMP1: begin
          pa <= PW'(cov) * PW'(bun);
          pb <= PW'(bov) * PW'(cun);
        end
        ST_CMP2: begin
          if (div_q >= min_iou && (!found || pa > pb || (pa == pb && cerr < berr))) begin
            found <= 1'b1;
            bt <= ti;
            bp <= pj;
            bov <= cov;
            bun <= cun;
            bq <= div_q;
            berr <= cerr;
          end
          if (pj + 1'b1 >= pcnt) begin
            pj <= '0;
            ti <= ti + 1'b1;
          end else pj <= pj + 1'b1;
        end
        ST_TAKE: if (emit) begin
          ttaken[bt[TAW-1:0]] <= 1'b1;
          ptaken[bp[PAW-1:0]] <= 1'b1;
          found <= 1'b0;
        end
        ST_EMIT_UP: if ((!ovalid || out.ready) && pj != pcnt) pj <= pj + 1'b1;
        ST_EMIT_UT: if ((!ovalid || out.ready) && ti != tcnt) ti <= ti + 1'b1;
        ST_WAIT: if (!ovalid) begin
          tcnt <= '0;
          pcnt <= '0;
          ttaken <= '0;
          ptaken <= '0;
        end
        default: ;
      endcase
    end
  end

  assign out.valid = ovalid;
  assign out.kind = okind;
  assign out.truth_idx = oti;
  assign out.pred_idx = opi;
  assign out.iou_q16 = oq;
  assign out.overlap_ticks = oov;
  assign out.boundary_error = oerr;
  assign out.last = olast;

  a_taken_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (ttaken == '0 && ptaken == '0))
    else $error("taken flags set while idle");
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    (tcnt <= TCW'(MAX_TRUTH) && pcnt <= PCW'(MAX_PRED)))
    else $error("count beyond capacity");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (ovalid && !out.ready) |=> (ovalid && $stable(oti) && $stable(okind)))
    else $error("output request changed under stall");
endmodule

[hw/rtl/gim_div.sv]
// ----------------------------------------------------------------------------
// gim_div
// restoring divider, one quotient bit per cycle, for (ov << 16) / union
// ----------------------------------------------------------------------------
module gim_div import gim_pkg::*; #(
  parameter int TB = TIME_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic go,
  input  logic [TB-1:0] ov,
  input  logic [TB:0] un,
  output logic busy,
  output logic [IOU_W-1:0] q
);
  localparam int NW = TB + 17;
  localparam int CW = $clog2(NW + 1);
  logic [NW-1:0] num;
  logic [TB+1:0] rem;
  logic [TB:0] den;
  logic [CW-1:0] cnt;
  logic [TB+1:0] trial;
  logic [NW-1:0] quo;

  assign trial = {rem[TB:0], num[NW-1]};
  assign q = (quo[NW-1:IOU_W] != '0) ? {IOU_W{1'b1}} : quo[IOU_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (go) begin
      busy <= 1'b1;
      cnt <= CW'(NW);
      num <= {1'b0, ov, 16'd0};
      den <= un;
      rem <= '0;
      quo <= '0;
    end else if (busy) begin
      num <= {num[NW-2:0], 1'b0};
      if (trial >= {1'b0, den}) begin
        rem <= trial - {1'b0, den};
        quo <= {quo[NW-2:0], 1'b1};
      end else begin
        rem <= trial;
        quo <= {quo[NW-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) busy <= 1'b0;
    end
  end
endmodule

[hw/rtl/gim_store.sv]
// ----------------------------------------------------------------------------
// gim_store
// interval memory, one write and one registered read port
// ----------------------------------------------------------------------------
module gim_store import gim_pkg::*; #(
  parameter int DEPTH = MAX_TRUTH_DEF,
  parameter int W = 80
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(DEPTH+1)-1:0] waddr,
  input  logic [W-1:0] wdata,
  input  logic [$clog2(DEPTH+1)-1:0] raddr,
  output logic [W-1:0] rdata
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  logic [W-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr[AW-1:0]] <= wdata;
    rdata <= mem[raddr[AW-1:0]];
  end
endmodule

[verif/greedy_iou_interval_matcher_top_test.sv]
// ----------------------------------------------------------------------------
// greedy_iou_interval_matcher_top_test
// self-checking bench of the greedy iou interval matcher: a directed table,
// then random scenes of reference and predicted intervals under several
// threshold and label settings, checked field by field against a predictor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module greedy_iou_interval_matcher_top_test;
  import gim_pkg::*;

  typedef struct packed {
    kind_t       kind;
    logic [3:0]  truth_idx;
    logic [3:0]  pred_idx;
    logic [16:0] iou_q16;
    logic [31:0] overlap_ticks;
    logic [32:0] boundary_error;
    logic        last;
  } match_res_t;

  typedef struct {
    op_t         op;
    logic [31:0] st;
    logic [31:0] en;
    logic [7:0]  ch;
    logic [7:0]  lb;
    bit          has_fix;
    match_res_t  fix;
    bit          hold_here;
  } req_t;

  typedef struct {
    logic [31:0] st;
    logic [31:0] en;
    logic [7:0]  ch;
    logic [7:0]  lb;
  } ivl_t;

  logic clk;
  logic rst;

  gim_in_if  in_ch();
  gim_out_if out_ch();
  gim_cfg_if cfg_ch();

  greedy_iou_interval_matcher_top dut (
    .clk(clk),
    .rst(rst),
    .in(in_ch),
    .out(out_ch),
    .cfg(cfg_ch)
  );

  ivl_t        truths[16];
  ivl_t        preds[16];
  int          n_truth;
  int          n_pred;
  logic [16:0] thr_q16;
  bit          same_label;

  match_res_t  pending_results[$];
  req_t        plan[$];
  int          mismatches;
  int          failures;
  bit          no_idle;
  bit          hold;
  bit          hold_go;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("[greedy_iou_interval_matcher_top] ERROR");
    $finish;
  end

  function automatic bit iou_gt(longint unsigned ova, longint unsigned una,
                                longint unsigned ovb, longint unsigned unb);
    logic [127:0] pa, pb;
    pa = {64'd0, ova} * {64'd0, unb};
    pb = {64'd0, ovb} * {64'd0, una};
    return pa > pb;
  endfunction

  function automatic match_res_t mk_res(kind_t k, int ti, int pi, longint unsigned q,
                                        longint unsigned ov, longint unsigned err);
    match_res_t r;
    r.kind = k;
    r.truth_idx = ti[3:0];
    r.pred_idx = pi[3:0];
    r.iou_q16 = q[16:0];
    r.overlap_ticks = ov[31:0];
    r.boundary_error = err[32:0];
    r.last = 1'b0;
    return r;
  endfunction

  function automatic void compute_matches(req_t r, ref match_res_t res[$]);
    bit t_taken[16];
    bit p_taken[16];
    longint unsigned lo, hi, ov, un, q, err, bov, bun, bq, berr;
    longint unsigned ts, te, ps, pe;
    bit found;
    int bt, bp;
    ivl_t v;
    res.delete();
    v.st = r.st;
    v.en = r.en;
    v.ch = r.ch;
    v.lb = r.lb;
    unique case (r.op)
      OP_LOAD_TRUTH: begin
        if (n_truth < 16) begin
          truths[n_truth] = v;
          n_truth++;
        end
      end
      OP_LOAD_PRED: begin
        if (n_pred < 16) begin
          preds[n_pred] = v;
          n_pred++;
        end
      end
      OP_RUN: begin
        if (n_truth == 0 && n_pred == 0) begin
          res = {res, mk_res(KIND_EMPTY, 0, 0, 0, 0, 0)};
        end else begin
          for (int i = 0; i < 16; i++) begin
            t_taken[i] = 0;
            p_taken[i] = 0;
          end
          forever begin
            found = 0;
            bt = 0;
            bp = 0;
            bov = 0;
            bun = 1;
            bq = 0;
            berr = 0;
            for (int i = 0; i < n_truth; i++) begin
              if (t_taken[i]) continue;
              for (int j = 0; j < n_pred; j++) begin
                if (p_taken[j]) continue;
                if (truths[i].ch != preds[j].ch) continue;
                if (same_label && truths[i].lb != preds[j].lb) continue;
                ts = truths[i].st;
                te = truths[i].en;
                ps = preds[j].st;
                pe = preds[j].en;
                lo = ts > ps ? ts : ps;
                hi = te < pe ? te : pe;
                if (hi <= lo) continue;
                ov = hi - lo;
                un = (te - ts) + (pe - ps) - ov;
                q = (ov << 16) / un;
                if (q < thr_q16) continue;
                err = (ps > ts ? ps - ts : ts - ps) + (pe > te ? pe - te : te - pe);
                if (!found || iou_gt(ov, un, bov, bun) ||
                    (!iou_gt(bov, bun, ov, un) && err < berr)) begin
                  found = 1;
                  bt = i;
                  bp = j;
                  bov = ov;
                  bun = un;
                  bq = q;
                  berr = err;
                end
              end
            end
            if (!found) break;
            t_taken[bt] = 1;
            p_taken[bp] = 1;
            res = {res, mk_res(KIND_MATCH, bt, bp, bq, bov, berr)};
          end
          for (int j = 0; j < n_pred; j++)
            if (!p_taken[j]) res = {res, mk_res(KIND_UPRED, 0, j, 0, 0, 0)};
          for (int i = 0; i < n_truth; i++)
            if (!t_taken[i]) res = {res, mk_res(KIND_UTRUTH, i, 0, 0, 0, 0)};
        end
        res[res.size()-1].last = 1'b1;
        n_truth = 0;
        n_pred = 0;
      end
      default: ;
    endcase
  endfunction

  function automatic void add(op_t op, logic [31:0] st, logic [31:0] en,
                              logic [7:0] ch, logic [7:0] lb);
    req_t r;
    r.op = op;
    r.st = st;
    r.en = en;
    r.ch = ch;
    r.lb = lb;
    r.has_fix = 0;
    r.fix = '0;
    r.hold_here = 0;
    plan = {plan, r};
  endfunction

  function automatic void add_fixed(op_t op, match_res_t fx);
    add(op, $urandom, $urandom, $urandom, $urandom);
    plan[plan.size()-1].has_fix = 1;
    plan[plan.size()-1].fix = fx;
  endfunction

  function automatic void gen_scene(int nt, int np, bit wide);
    logic [31:0] s, l, ps, pl;
    logic [7:0] c, b;
    int placed_t, placed_p;
    placed_t = 0;
    placed_p = 0;
    while (placed_t < nt || placed_p < np) begin
      s = wide ? $urandom : $urandom_range(0, 3000);
      l = $urandom_range(1, 400);
      c = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 1)) * 8'd255;
      b = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 2));
      if (placed_t < nt) begin
        add(OP_LOAD_TRUTH, s, s + l, c, b);
        placed_t++;
      end
      if (placed_p < np) begin
        ps = s + $urandom_range(0, 60) - 30;
        pl = l + $urandom_range(0, 60) - 30;
        if ($urandom_range(0, 5) == 0) b = 8'($urandom_range(0, 2));
        if ($urandom_range(0, 7) == 0) add(OP_LOAD_PRED, $urandom, $urandom, c, b);
        else add(OP_LOAD_PRED, ps, ps + pl, c, b);
        placed_p++;
      end
      if ($urandom_range(0, 15) == 0) add(OP_NONE, $urandom, $urandom, $urandom, $urandom);
    end
    add(OP_RUN, $urandom, $urandom, $urandom, $urandom);
  endfunction

  task automatic send_plan();
    req_t r;
    match_res_t res[$];
    int gap;
    while (plan.size() > 0) begin
      r = plan.pop_front();
      gap = no_idle ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      if (r.hold_here) hold_go = 1;
      in_ch.valid <= 1'b1;
      in_ch.op <= r.op;
      in_ch.start_time <= r.st;
      in_ch.end_time <= r.en;
      in_ch.channel_id <= r.ch;
      in_ch.label_id <= r.lb;
      do @(posedge clk); while (!in_ch.ready);
      compute_matches(r, res);
      if (r.has_fix) pending_results = {pending_results, r.fix};
      else foreach (res[k]) pending_results = {pending_results, res[k]};
    end
    in_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_results.size() > 0) @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [16:0] val);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= {15'($urandom), val};
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == CFG_MIN_IOU) thr_q16 = val;
    else same_label = val[0];
  endtask

  // receiver ready with random stalls and the long hold
  initial begin
    int w;
    out_ch.ready = 1'b0;
    @(negedge rst);
    forever begin
      w = no_idle ? 0 : $urandom_range(0, 16);
      if (w > 0) begin
        out_ch.ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      while (hold) begin
        out_ch.ready <= 1'b0;
        @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  initial begin
    hold = 0;
    wait (hold_go);
    hold = 1;
    repeat (3000) @(posedge clk);
    hold = 0;
  end

  always @(posedge clk) begin
    match_res_t got, want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got.kind = kind_t'(out_ch.kind);
      got.truth_idx = out_ch.truth_idx;
      got.pred_idx = out_ch.pred_idx;
      got.iou_q16 = out_ch.iou_q16;
      got.overlap_ticks = out_ch.overlap_ticks;
      got.boundary_error = out_ch.boundary_error;
      got.last = out_ch.last;
      if (pending_results.size() == 0) begin
        failures++;
        $display("unexpected result %p", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  initial begin
    logic [16:0] thr_set[5];
    bit lbl_set[5];
    match_res_t fx;
    mismatches = 0;
    failures = 0;
    no_idle = 0;
    hold_go = 0;
    n_truth = 0;
    n_pred = 0;
    thr_q16 = MIN_IOU_RST;
    same_label = 1;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.op = OP_NONE;
    in_ch.start_time = '0;
    in_ch.end_time = '0;
    in_ch.channel_id = '0;
    in_ch.label_id = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_MIN_IOU;
    cfg_ch.data = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed table
    fx = mk_res(KIND_EMPTY, 0, 0, 0, 0, 0);
    fx.last = 1'b1;
    add_fixed(OP_RUN, fx);
    add(OP_LOAD_TRUTH, 32'd0, 32'd100, 8'd1, 8'd2);
    add(OP_LOAD_PRED, 32'd0, 32'd100, 8'd1, 8'd2);
    fx = mk_res(KIND_MATCH, 0, 0, 65536, 100, 0);
    fx.last = 1'b1;
    add_fixed(OP_RUN, fx);
    add(OP_LOAD_TRUTH, 32'd0, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
    add(OP_LOAD_PRED, 32'd1, 32'hFFFF_FFFE, 8'hFF, 8'hFF);
    add(OP_LOAD_PRED, 32'd0, 32'hFFFF_FFFF, 8'hFF, 8'h00);
    add(OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
    add(OP_RUN, 32'd0, 32'd0, 8'd0, 8'd0);
    add(OP_LOAD_TRUTH, 32'd500, 32'd400, 8'd0, 8'd0);
    add(OP_LOAD_PRED, 32'd400, 32'd500, 8'd0, 8'd0);
    add(OP_LOAD_TRUTH, 32'd10, 32'd10, 8'd0, 8'd0);
    add(OP_LOAD_PRED, 32'd10, 32'd20, 8'd1, 8'd0);
    add(OP_RUN, 32'd0, 32'd0, 8'd0, 8'd0);
    add(OP_LOAD_TRUTH, 32'd0, 32'd100, 8'd3, 8'd1);
    add(OP_LOAD_TRUTH, 32'd0, 32'd100, 8'd3, 8'd1);
    add(OP_LOAD_PRED, 32'd0, 32'd100, 8'd3, 8'd1);
    add(OP_LOAD_PRED, 32'd5, 32'd105, 8'd3, 8'd1);
    add(OP_LOAD_PRED, 32'd200, 32'd300, 8'd3, 8'd1);
    add(OP_RUN, 32'd0, 32'd0, 8'd0, 8'd0);
    add(OP_LOAD_PRED, 32'd7, 32'd9, 8'd4, 8'd4);
    fx = mk_res(KIND_UPRED, 0, 0, 0, 0, 0);
    fx.last = 1'b1;
    add_fixed(OP_RUN, fx);
    send_plan();

    thr_set = '{17'd1, 17'd65536, 17'd0, 17'd131071, 17'd30000};
    lbl_set = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(CFG_MIN_IOU, thr_set[ph]);
      write_reg(CFG_SAME_LABEL, 17'(lbl_set[ph]));
      no_idle = (ph == 3);
      if (ph == 1) begin
        gen_scene(17, 17, 0);
      end
      if (ph == 4) begin
        gen_scene(18, 17, 1);
      end
      while (plan.size() < 35) gen_scene($urandom_range(0, 4), $urandom_range(0, 4),
                                         $urandom_range(0, 4) == 0);
      if (ph == 2) begin
        foreach (plan[k])
          if (plan[k].op == OP_RUN) begin
            plan[k].hold_here = 1;
            break;
          end
      end
      send_plan();
    end
    write_reg(CFG_MIN_IOU, MIN_IOU_RST);
    write_reg(CFG_SAME_LABEL, 17'd1);
    while (plan.size() < 20) gen_scene($urandom_range(1, 4), $urandom_range(1, 4), 0);
    send_plan();

    drain();
    repeat (200) @(posedge clk);
    if (mismatches == 0 && failures == 0 && pending_results.size() == 0) begin
      $display("[greedy_iou_interval_matcher_top] OK");
    end else begin
      $display("[greedy_iou_interval_matcher_top] ERROR");
    end
    $finish;
  end

endmodule

[greedy_iou_interval_matcher_top.f]
hw/rtl/gim_pkg.sv
hw/rtl/gim_if.sv
hw/rtl/gim_div.sv
hw/rtl/gim_store.sv
hw/rtl/greedy_iou_interval_matcher_top.sv
verif/greedy_iou_interval_matcher_top_test.sv
